[rtl/cse_pkg.sv]
package cse_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegionW = 2;
  localparam logic [RegionW-1:0] RegionLeft = 2'd0;
  localparam logic [RegionW-1:0] RegionInner = 2'd1;
  localparam logic [RegionW-1:0] RegionRight = 2'd2;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  localparam int unsigned CoefA = 0;
  localparam int unsigned CoefB = 1;
  localparam int unsigned CoefC = 2;
  localparam int unsigned CoefD = 3;

  localparam logic [0:0] AddrKnotCount = 1'b0;

  typedef enum logic [3:0] {
    StIdle,
    StWrite,
    StSearch,
    StSearchWait,
    StEdge,
    StEdgeWait,
    StCoef,
    StCoefWait,
    StMul1,
    StMul2,
    StMul3,
    StMul4,
    StOut
  } state_e;

endpackage

[rtl/cse_ram.sv]
module cse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/cubic_spline_evaluator.sv]
// Piecewise cubic spline evaluator. Knot positions and per-segment
// coefficients a, b, c, d live in two synchronous RAMs with one read port each.
// A write word (mode 0) stores its knot and four coefficients in StWrite, and
// no new word is taken until the store is done; an entry_index at or above
// MAX_KNOTS is dropped. A query word (mode 1) runs a lower-bound binary search
// over knot_count knots, one RAM probe per StSearch/StSearchWait pair, reads
// the edge knots and the four coefficients, then forms h in StMul1 and
// evaluates Horner form in the StMul states with one 32x32 multiplier; an
// inner query takes a final step on a second one, while a query outside the
// knots uses b, c and d only. The result is loaded as the block returns to
// idle, so a new word can be taken while it waits; a result that is not taken
// holds the next query in StOut until it is. knot_count is clamped to
// 2..MAX_KNOTS. All values are signed with FRAC_BITS fraction bits; results
// saturate and set saturated_o. Read an entry only after writing it.
module cubic_spline_evaluator #(
  parameter int unsigned MAX_KNOTS = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [5:0]                  entry_index_i,
  input  logic signed [31:0]          knot_x_i,
  input  logic signed [31:0]          coef_cubic_i,
  input  logic signed [31:0]          coef_quad_i,
  input  logic signed [31:0]          coef_lin_i,
  input  logic signed [31:0]          coef_const_i,
  input  logic signed [31:0]          query_x_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [31:0]          value_o,
  output logic signed [31:0]          first_deriv_o,
  output logic signed [31:0]          deriv2_o,
  output logic [5:0]                  segment_o,
  output logic [1:0]                  region_o,
  output logic                        saturated_o
);
  import cse_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_KNOTS);
  localparam int unsigned CntW = $clog2(MAX_KNOTS + 1);
  localparam int unsigned CoefDepth = 4 * MAX_KNOTS;
  localparam int unsigned CoefAw = $clog2(CoefDepth);
  localparam logic signed [63:0] Smax = 64'sd2147483647;
  localparam logic signed [63:0] Smin = -64'sd2147483648;
  localparam logic signed [63:0] RoundK = 64'sd1 <<< (FRAC_BITS - 1);

  function automatic logic signed [31:0] sat(input logic signed [63:0] v,
                                             inout logic f);
    logic signed [31:0] r;
    if (v > Smax) begin
      f = 1'b1;
      r = 32'sh7fffffff;
    end else if (v < Smin) begin
      f = 1'b1;
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic [6:0] knot_count_q;
  logic [CntW-1:0] n_eff;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == AddrKnotCount) ? {25'd0, knot_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= 7'd2;
    end else if (cfg_wr && paddr[2] == AddrKnotCount) begin
      knot_count_q <= pwdata[6:0];
    end
  end

  always_comb begin
    if (knot_count_q < 7'd2) begin
      n_eff = CntW'(2);
    end else if (32'(knot_count_q) > MAX_KNOTS) begin
      n_eff = CntW'(MAX_KNOTS);
    end else begin
      n_eff = CntW'(knot_count_q);
    end
  end

  state_e state_q, state_d;
  logic [IdxW-1:0] widx_q;
  logic signed [31:0] wk_q, wa_q, wb_q, wc_q, wd_q, x_q;
  logic [1:0] wsel_q, wsel_d;
  logic [CntW-1:0] lo_q, lo_d, len_q, len_d, nn_q;
  logic [IdxW-1:0] e_q, e_d;
  logic [1:0] region_q, region_d;
  logic signed [31:0] k0_q, ke_q, a_q, b_q, c_q, d_q;
  logic signed [31:0] h_q, t1_q, t2_q;
  logic flag_q;
  logic [1:0] csel_q;
  logic out_valid_q;
  logic signed [31:0] val_q, d1_q, d2_q;

  logic kwe, cwe;
  logic [IdxW-1:0] kraddr;
  logic [CoefAw-1:0] craddr, cwaddr;
  logic signed [31:0] kdata, cdata, cwdata;

  cse_ram #(.Width(WordW), .Depth(MAX_KNOTS)) u_knot_ram (
    .clk_i, .we_i(kwe), .waddr_i(widx_q), .wdata_i(wk_q),
    .raddr_i(kraddr), .rdata_o(kdata)
  );

  cse_ram #(.Width(WordW), .Depth(CoefDepth)) u_coef_ram (
    .clk_i, .we_i(cwe), .waddr_i(cwaddr), .wdata_i(cwdata),
    .raddr_i(craddr), .rdata_o(cdata)
  );

  logic in_fire, out_fire;
  assign in_ready_o = (state_q == StIdle);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;

  logic [CntW-1:0] half;
  assign half = len_q >> 1;
  logic [CntW-1:0] probe;
  assign probe = lo_q + half;

  always_comb begin
    kraddr = probe[IdxW-1:0];
    if (state_q == StEdge) begin
      kraddr = '0;
    end else if (state_q == StEdgeWait) begin
      kraddr = IdxW'(nn_q - CntW'(1));
    end else if (state_q == StCoef) begin
      kraddr = (lo_q == '0) ? '0 : IdxW'(lo_q - CntW'(1));
    end
  end

  assign kwe = (state_q == StWrite) && (wsel_q == 2'd0);
  assign cwe = (state_q == StWrite);
  assign cwaddr = {widx_q, wsel_q};
  always_comb begin
    case (wsel_q)
      2'(CoefA): cwdata = wa_q;
      2'(CoefB): cwdata = wb_q;
      2'(CoefC): cwdata = wc_q;
      default: cwdata = wd_q;
    endcase
  end
  assign craddr = {e_q, csel_q};

  // multiplier and adders
  logic signed [31:0] mop_a, mop_b;
  logic signed [63:0] prod, rm;
  always_comb begin
    mop_a = a_q;
    case (state_q)
      StMul2: mop_a = (region_q == RegionInner) ? a_q : b_q;
      StMul3: mop_a = t1_q;
      StMul4: mop_a = t2_q;
      default: mop_a = a_q;
    endcase
    mop_b = h_q;
    prod = mop_a * mop_b + RoundK;
    rm = prod >>> FRAC_BITS;
  end

  logic signed [63:0] hx;
  assign hx = 64'(x_q) - 64'(ke_q);

  always_comb begin
    state_d = state_q;
    lo_d = lo_q;
    len_d = len_q;
    e_d = e_q;
    region_d = region_q;
    wsel_d = wsel_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (mode_i == ModeWrite) begin
            state_d = (32'(entry_index_i) < MAX_KNOTS) ? StWrite : StIdle;
          end else begin
            state_d = StSearch;
          end
          lo_d = '0;
          len_d = n_eff;
          wsel_d = '0;
        end
      end
      StWrite: begin
        wsel_d = wsel_q + 2'd1;
        if (wsel_q == 2'd3) state_d = StIdle;
      end
      StSearch: begin
        if (len_q == '0) state_d = StEdge;
        else state_d = StSearchWait;
      end
      StSearchWait: begin
        if (kdata < x_q) begin
          lo_d = probe + CntW'(1);
          len_d = len_q - half - CntW'(1);
        end else begin
          len_d = half;
        end
        state_d = StSearch;
      end
      StEdge: state_d = StEdgeWait;
      StEdgeWait: state_d = StCoef;
      StCoef: begin
        if (x_q < k0_q) begin
          region_d = RegionLeft;
          e_d = '0;
        end else if (x_q > kdata) begin
          region_d = RegionRight;
          e_d = IdxW'(nn_q - CntW'(1));
        end else begin
          region_d = RegionInner;
          e_d = (lo_q == '0) ? '0 : IdxW'(lo_q - CntW'(1));
        end
        state_d = StCoefWait;
      end
      StCoefWait: if (csel_q == 2'd3) state_d = StMul1;
      StMul1: state_d = StMul2;
      StMul2: state_d = StMul3;
      StMul3: state_d = StMul4;
      StMul4: state_d = StOut;
      StOut: if (!out_valid_q || out_fire) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      lo_q <= '0;
      len_q <= '0;
      wsel_q <= '0;
      csel_q <= '0;
    end else begin
      state_q <= state_d;
      lo_q <= lo_d;
      len_q <= len_d;
      wsel_q <= wsel_d;
      if (state_q == StCoef) csel_q <= '0;
      else if (state_q == StCoefWait) csel_q <= csel_q + 2'd1;
      if (state_q == StOut && (!out_valid_q || out_fire)) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic f;
    e_q <= e_d;
    region_q <= region_d;
    if (in_fire) begin
      widx_q <= IdxW'(entry_index_i);
      wk_q <= knot_x_i;
      wa_q <= coef_cubic_i;
      wb_q <= coef_quad_i;
      wc_q <= coef_lin_i;
      wd_q <= coef_const_i;
      x_q <= query_x_i;
      nn_q <= n_eff;
      flag_q <= 1'b0;
    end
    if (state_q == StEdgeWait) k0_q <= kdata;
    if (state_q == StCoef) begin
      if (x_q < k0_q) ke_q <= k0_q;
      else if (x_q > kdata) ke_q <= kdata;
      else ke_q <= '0;
    end
    if (state_q == StCoefWait) begin
      case (csel_q)
        2'd1: a_q <= cdata;
        2'd2: b_q <= cdata;
        2'd3: c_q <= cdata;
        default: ;
      endcase
      if (csel_q == 2'd0 && region_q == RegionInner) ke_q <= kdata;
    end
    f = flag_q;
    case (state_q)
      StMul1: begin
        d_q <= cdata;
        h_q <= sat(hx, f);
        flag_q <= f;
      end
      StMul2: begin
        if (region_q == RegionInner) begin
          t1_q <= sat(rm + 64'(b_q), f);
          t2_q <= sat(3 * rm + 2 * 64'(b_q), f);
          d2_q <= sat(6 * rm + 2 * 64'(b_q), f);
        end else begin
          t1_q <= sat(rm + 64'(c_q), f);
          d1_q <= sat(2 * rm + 64'(c_q), f);
          d2_q <= sat(2 * 64'(b_q), f);
        end
        flag_q <= f;
      end
      StMul3: begin
        if (region_q == RegionInner) t1_q <= sat(rm + 64'(c_q), f);
        else val_q <= sat(rm + 64'(d_q), f);
        flag_q <= f;
      end
      StMul4: begin
        if (region_q == RegionInner) begin
          d1_q <= sat(rm + 64'(c_q), f);
          t2_q <= t1_q;
          flag_q <= f;
        end
      end
      default: ;
    endcase
  end

  // final value step for the interior: one more multiply on the held sum
  logic signed [63:0] pv, rv;
  logic fv;
  logic signed [31:0] vfin;
  always_comb begin
    pv = t2_q * h_q + RoundK;
    rv = pv >>> FRAC_BITS;
    fv = flag_q;
    vfin = sat(rv + 64'(d_q), fv);
  end

  logic signed [31:0] val_o_q;
  logic flag_o_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StOut && (!out_valid_q || out_fire)) begin
      val_o_q <= (region_q == RegionInner) ? vfin : val_q;
      flag_o_q <= (region_q == RegionInner) ? fv : flag_q;
      first_deriv_o <= d1_q;
      deriv2_o <= d2_q;
      segment_o <= 6'(e_q);
      region_o <= region_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o = val_o_q;
  assign saturated_o = flag_o_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_reg_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> region_o != 2'd3) else $error("bad region");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q) else $error("result dropped");
`endif

endmodule

[tb/cubic_spline_evaluator_tb.sv]
`timescale 1ns / 100ps

module cubic_spline_evaluator_tb;
  import cse_pkg::*;

  localparam int unsigned NumKnots = 64;
  localparam int unsigned FracBits = 16;
  localparam int unsigned TimeoutCycles = 20000;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] first_deriv;
    logic signed [31:0] deriv2;
    logic [5:0]         segment;
    logic [1:0]         region;
    logic               saturated;
  } spline_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = ModeWrite;
  logic [5:0] entry_index_i = '0;
  logic signed [31:0] knot_x_i = '0;
  logic signed [31:0] coef_cubic_i = '0;
  logic signed [31:0] coef_quad_i = '0;
  logic signed [31:0] coef_lin_i = '0;
  logic signed [31:0] coef_const_i = '0;
  logic signed [31:0] query_x_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] value_o;
  logic signed [31:0] first_deriv_o;
  logic signed [31:0] deriv2_o;
  logic [5:0] segment_o;
  logic [1:0] region_o;
  logic saturated_o;

  cubic_spline_evaluator uut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic signed [63:0] knot_pos [NumKnots];
  logic signed [63:0] coefs [NumKnots][4];
  int unsigned knot_cnt;

  spline_result_t expected_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned queries_sent;
  int unsigned writes_sent;
  int unsigned idle_cycles;
  int unsigned sat_seen;
  int unsigned region_seen [3];
  bit idle_en;

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v,
                                                inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] p,
                                              input logic signed [63:0] q);
    logic signed [63:0] r;
    r = p * q + (64'sd1 <<< (FracBits - 1));
    return r >>> FracBits;
  endfunction

  function automatic spline_result_t eval_spline(input logic signed [31:0] qx);
    spline_result_t r;
    int unsigned n, lo, len, half, e;
    logic signed [63:0] x, h, a, b, c, d, m, t;
    bit flag;
    flag = 1'b0;
    n = (knot_cnt < 2) ? 2 : (knot_cnt > NumKnots ? NumKnots : knot_cnt);
    x = qx;
    lo = 0;
    len = n;
    while (len > 0) begin
      half = len >> 1;
      if (knot_pos[lo + half] < x) begin
        lo += half + 1;
        len -= half + 1;
      end else begin
        len = half;
      end
    end
    if (x < knot_pos[0]) begin
      r.region = RegionLeft;
      e = 0;
    end else if (x > knot_pos[n-1]) begin
      r.region = RegionRight;
      e = n - 1;
    end else begin
      r.region = RegionInner;
      e = (lo > 0) ? lo - 1 : 0;
    end
    h = clip32(x - knot_pos[e], flag);
    a = coefs[e][CoefA];
    b = coefs[e][CoefB];
    c = coefs[e][CoefC];
    d = coefs[e][CoefD];
    if (r.region == RegionInner) begin
      m = qmul(a, h);
      t = clip32(m + b, flag);
      t = clip32(qmul(t, h) + c, flag);
      r.value = 32'(clip32(qmul(t, h) + d, flag));
      t = clip32(3 * m + 2 * b, flag);
      r.first_deriv = 32'(clip32(qmul(t, h) + c, flag));
      r.deriv2 = 32'(clip32(6 * m + 2 * b, flag));
    end else begin
      m = qmul(b, h);
      t = clip32(m + c, flag);
      r.value = 32'(clip32(qmul(t, h) + d, flag));
      r.first_deriv = 32'(clip32(2 * m + c, flag));
      r.deriv2 = 32'(clip32(2 * b, flag));
    end
    r.segment = e[5:0];
    r.saturated = flag;
    return r;
  endfunction

  task automatic wait_idle_gap();
    while (idle_en && $urandom_range(99) < 36) begin
      idle_cycles++;
      @(negedge clk_i);
    end
  endtask

  task automatic send_word(input logic md, input logic [5:0] idx,
                           input logic signed [31:0] kx, input logic signed [31:0] ca,
                           input logic signed [31:0] cb, input logic signed [31:0] cc,
                           input logic signed [31:0] cd, input logic signed [31:0] qx);
    wait_idle_gap();
    @(negedge clk_i);
    mode_i <= md;
    entry_index_i <= idx;
    knot_x_i <= kx;
    coef_cubic_i <= ca;
    coef_quad_i <= cb;
    coef_lin_i <= cc;
    coef_const_i <= cd;
    query_x_i <= qx;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (md == ModeWrite) begin
      knot_pos[idx] = kx;
      coefs[idx][CoefA] = ca;
      coefs[idx][CoefB] = cb;
      coefs[idx][CoefC] = cc;
      coefs[idx][CoefD] = cd;
      writes_sent++;
    end else begin
      expected_q.insert(expected_q.size(), eval_spline(qx));
      queries_sent++;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic store_knot(input int unsigned idx, input logic signed [31:0] kx,
                            input logic signed [31:0] ca, input logic signed [31:0] cb,
                            input logic signed [31:0] cc, input logic signed [31:0] cd);
    send_word(ModeWrite, idx[5:0], kx, ca, cb, cc, cd, $urandom);
  endtask

  task automatic query_at(input logic signed [31:0] qx);
    send_word(ModeQuery, 6'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
              qx);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic set_knot_count(input int unsigned cnt);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {AddrKnotCount, 2'b00};
    pwdata <= cnt;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    knot_cnt = cnt & 32'h7f;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2 * 65536)) - 65536;
      2: return $signed($urandom_range(64 * 65536)) - 32 * 65536;
      default: return $signed($urandom_range(4096)) - 2048;
    endcase
  endfunction

  // ascending knots; spacing chosen per table
  task automatic load_table(input int unsigned cnt, input bit wide);
    logic signed [63:0] pos;
    int unsigned step;
    pos = wide ? -64'sd2147483648 + $urandom_range(1000) : $signed($urandom_range(65536 * 40)) - 65536 * 20;
    step = wide ? 32'd4294967295 / cnt : $urandom_range(65536 * 4, 1);
    for (int unsigned i = 0; i < cnt; i++) begin
      store_knot(i, pos[31:0], rand_coef(), rand_coef(), rand_coef(), rand_coef());
      pos += $urandom_range(step, 1);
      if (pos > 64'sd2147483647) pos = 64'sd2147483647;
    end
  endtask

  function automatic logic signed [31:0] pick_query(input int unsigned cnt);
    int unsigned k;
    k = $urandom_range(cnt - 1);
    case ($urandom_range(5))
      0: return $urandom;
      1: return knot_pos[k][31:0];
      2: return knot_pos[k][31:0] + $signed($urandom_range(131072)) - 65536;
      3: return 32'((k + 1 < cnt) ? (knot_pos[k] + knot_pos[k+1]) >>> 1 : knot_pos[k] + 1);
      4: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return 32'(knot_pos[0] - $urandom_range(65536));
    endcase
  endfunction

  task automatic test_directed();
    set_knot_count(3);
    store_knot(0, -32'sd65536, 32'sd65536, 32'sd0, 32'sd0, 32'sd0);
    store_knot(1, 32'sd0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    store_knot(2, 32'sd131072, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    query_at(32'sh8000_0000);
    query_at(-32'sd65536);
    query_at(-32'sd32768);
    query_at(32'sd0);
    query_at(32'sd1);
    query_at(32'sd131072);
    query_at(32'sd131073);
    query_at(32'sh7fff_ffff);
    drain();
    // h overflows: both knots at the far ends
    set_knot_count(2);
    store_knot(0, 32'sh8000_0000, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
    store_knot(1, 32'sh7fff_ffff, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    query_at(32'sh7fff_fffe);
    query_at(32'sh8000_0000);
    query_at(32'sh7fff_ffff);
    // index above table size is still in range at six bits
    store_knot(63, 32'sh7fff_ffff, 32'sd5, 32'sd6, 32'sd7, 32'sd8);
    drain();
    // out of range counts clamp
    set_knot_count(0);
    query_at(32'sd0);
    drain();
    set_knot_count(1);
    query_at(32'sh7fff_ffff);
    drain();
  endtask

  task automatic test_tables(input int unsigned rounds);
    int unsigned cnt;
    for (int unsigned r = 0; r < rounds; r++) begin
      case (r % 4)
        0: cnt = 64;
        1: cnt = 2;
        default: cnt = $urandom_range(64, 2);
      endcase
      drain();
      set_knot_count((r == 5) ? 127 : cnt);
      if (r == 5) cnt = 64;
      load_table(cnt, r % 3 == 0);
      for (int unsigned q = 0; q < 40; q++) begin
        if ($urandom_range(15) == 0) begin
          int unsigned k;
          logic signed [63:0] lo_b, hi_b;
          k = $urandom_range(cnt - 1);
          lo_b = (k == 0) ? -64'sd2147483648 : knot_pos[k-1];
          hi_b = (k == cnt - 1) ? 64'sd2147483647 : knot_pos[k+1];
          store_knot(k, 32'((lo_b + hi_b) >>> 1), rand_coef(), rand_coef(), rand_coef(),
                     rand_coef());
        end else begin
          query_at(pick_query(cnt));
        end
      end
    end
  endtask

  task automatic test_pause_until_empty();
    query_at(pick_query(knot_cnt < 2 ? 2 : (knot_cnt > 64 ? 64 : knot_cnt)));
    while (expected_q.size() != 0) @(negedge clk_i);
    query_at(pick_query(knot_cnt < 2 ? 2 : (knot_cnt > 64 ? 64 : knot_cnt)));
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= !idle_en || ($urandom_range(99) >= 36);
  end

  always @(posedge clk_i) begin
    spline_result_t got, exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{value_o, first_deriv_o, deriv2_o, segment_o, region_o, saturated_o};
      results_seen++;
      if (got.region < 3) region_seen[got.region]++;
      if (got.saturated) sat_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result %0d expected %p got %p",
                                         results_seen, exp_r, got);
        end
      end
    end
  end

  int unsigned stall_cnt;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni ||
        (!in_valid_i && expected_q.size() == 0)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= TimeoutCycles) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    idle_en = 1'b1;
    knot_cnt = 2;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_tables(6);
    test_pause_until_empty();
    idle_en = 1'b0;
    test_tables(3);
    idle_en = 1'b1;
    test_tables(3);
    drain();
    $display("Sent %0d knot writes and %0d queries; %0d results checked, %0d saturated.",
             writes_sent, queries_sent, results_seen, sat_seen);
    $display("Regions seen: left %0d, inner %0d, right %0d; %0d idle cycles.",
             region_seen[0], region_seen[1], region_seen[2], idle_cycles);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cse_pkg.sv
rtl/cse_ram.sv
rtl/cubic_spline_evaluator.sv
tb/cubic_spline_evaluator_tb.sv
